### src/ammd_pkg.sv
// Shared types and constants for the arcade memory map decoder.
// Holds the request and response structs, mode and source codes, and map constants.
// No dependencies.
package ammd_pkg;

    localparam int ROM_BYTES_DEF  = 16384;
    localparam int FLAT_BYTES_DEF = 65536;
    localparam int RAM_AREA_BYTES = 4096;  // video, colour and work RAM, 4000-4FFF

    localparam logic [7:0] DIP_RESET  = 8'hC9;
    localparam logic [7:0] BYTE_FF    = 8'hFF;
    localparam logic [7:0] BYTE_ZERO  = 8'h00;

    localparam logic [1:0] ROM_AREA   = 2'h0;   // address[15:14]
    localparam logic [3:0] RAM_AREA   = 4'h4;   // address[15:12]
    localparam logic [7:0] IO_PAGE    = 8'h50;  // address[15:8]
    localparam logic [7:0] IRQ_OFFSET = 8'h00;
    localparam logic [3:0] SPRITE_NIB = 4'h6;   // offsets 60-6F

    localparam logic [1:0] IO_PORT0   = 2'd0;   // offset[7:6]
    localparam logic [1:0] IO_PORT1   = 2'd1;
    localparam logic [1:0] IO_DIP     = 2'd2;
    localparam logic [1:0] IO_OPEN    = 2'd3;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 8;
    localparam logic [CFG_IDX_W-1:0] CFG_FLAT_MODE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DIP       = 1'd1;

    typedef enum logic [1:0] {
        MODE_READ  = 2'd0,
        MODE_WRITE = 2'd1,
        MODE_LOAD  = 2'd2,
        MODE_PEEK  = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        SRC_BYTE = 2'd0,
        SRC_MAP  = 2'd1,
        SRC_FLAT = 2'd2
    } t_src;

    typedef struct packed {
        t_mode       mode;
        logic [15:0] address;
        logic [7:0]  write_data;
        logic [7:0]  port0_levels;
        logic [7:0]  port1_levels;
    } t_req;

    typedef struct packed {
        logic [7:0] read_data;
        logic       irq_enable;
    } t_rsp;

endpackage

### src/ammd_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// Used for the mapped stores and the flat store. No dependencies.
module ammd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        r_rdata <= mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### src/arcade_memory_map_decoder.sv
// Top level of the arcade memory map decoder: bus decode, stores and response buffering.
// Depends on ammd_pkg and ammd_ram.
//
// One request is one CPU bus access (read, write, ROM load or side-effect-free peek) and
// gives one response. A request is taken into the read stage while the memories do
// their registered read, and the response then lands in the output register; the next
// request is taken only once the read stage is empty again, so a request is never
// taken while the last one is still being read. A response waiting on the output
// does not stop the next request: a skid register holds the one that follows.
// ROM, video, colour and work RAM share one memory of ROM_BYTES + 4096 bytes (ROM at
// the bottom, the 4000-4FFF area above it); flat mode uses a second memory of
// FLAT_BYTES. After reset both memories are swept to zero, and every write of 1 to
// flat_mode sweeps the flat memory again; during a sweep no request is taken while
// configuration writes are still accepted. Sprite bytes and the interrupt enable bit
// live in flip-flops.
module arcade_memory_map_decoder
    import ammd_pkg::*;
#(
    parameter int ROM_BYTES  = ROM_BYTES_DEF,
    parameter int FLAT_BYTES = FLAT_BYTES_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_req_valid,
    output logic                  o_req_ready,
    input  t_req                  i_req,
    output logic                  o_rsp_valid,
    input  logic                  i_rsp_ready,
    output t_rsp                  o_rsp,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int MAP_DEPTH = ROM_BYTES + RAM_AREA_BYTES;
    localparam int MAP_AW    = $clog2(MAP_DEPTH);
    localparam int FLAT_AW   = $clog2(FLAT_BYTES);
    localparam int CLR_DEPTH = (MAP_DEPTH > FLAT_BYTES) ? MAP_DEPTH : FLAT_BYTES;
    localparam int CLR_W     = $clog2(CLR_DEPTH);

    // configuration and small state
    logic             r_flat_mode;
    logic [7:0]       r_dip;
    logic             r_irq;
    logic [7:0]       r_sprite [16];

    // clearing sweep
    logic             r_clr_map;
    logic             r_clr_flat;
    logic [CLR_W-1:0] r_clr_cnt;

    // read stage and output buffers
    logic             r_s1_valid;
    t_src             r_s1_src;
    logic [7:0]       r_s1_byte;
    logic             r_out_valid;
    t_rsp             r_out;
    logic             r_skid_valid;
    t_rsp             r_skid;
    logic             n_out_valid;
    t_rsp             n_out;
    logic             n_skid_valid;
    t_rsp             n_skid;

    logic             clearing;
    logic             accept;
    logic             take;

    // decode results
    t_src             dec_src;
    logic [7:0]       dec_byte;
    logic             dec_map_we;
    logic             dec_flat_we;
    logic [MAP_AW-1:0] dec_map_addr;
    logic             dec_irq_we;
    logic             dec_spr_we;

    logic             rom_hit;
    logic             flat_hit;
    logic             in_rom_area;
    logic             in_ram_area;
    logic             in_io_page;
    logic [7:0]       io_off;

    // memory ports
    logic              map_we;
    logic [MAP_AW-1:0] map_waddr;
    logic [7:0]        map_wdata;
    logic [7:0]        map_rdata;
    logic              clr_map_we;
    logic              flat_we;
    logic [FLAT_AW-1:0] flat_waddr;
    logic [7:0]        flat_wdata;
    logic [7:0]        flat_rdata;
    logic              clr_flat_we;

    t_rsp              rsp_s1;

    assign clearing    = r_clr_map | r_clr_flat;
    assign o_req_ready = !clearing && !r_s1_valid && !r_skid_valid;
    assign accept      = i_req_valid && o_req_ready;
    assign take        = r_out_valid && i_rsp_ready;

    // region decode of the bus address
    assign in_rom_area = (i_req.address[15:14] == ROM_AREA);
    assign in_ram_area = (i_req.address[15:12] == RAM_AREA);
    assign in_io_page  = (i_req.address[15:8] == IO_PAGE);
    assign io_off      = i_req.address[7:0];
    assign rom_hit     = ({1'b0, i_req.address} < 17'(ROM_BYTES));
    assign flat_hit    = ({1'b0, i_req.address} < 17'(FLAT_BYTES));

    // ROM sits at the bottom of the shared memory, the 4000-4FFF area right above it
    always_comb begin
        if (in_rom_area) begin
            dec_map_addr = MAP_AW'(i_req.address[13:0]);
        end else begin
            dec_map_addr = MAP_AW'(ROM_BYTES) + MAP_AW'(i_req.address[11:0]);
        end
    end

    always_comb begin
        dec_src     = SRC_BYTE;
        dec_byte    = BYTE_ZERO;
        dec_map_we  = 1'b0;
        dec_flat_we = 1'b0;
        dec_irq_we  = 1'b0;
        dec_spr_we  = 1'b0;
        unique case (i_req.mode)
            MODE_READ: begin
                dec_byte = BYTE_FF;
                if (r_flat_mode) begin
                    if (flat_hit) dec_src = SRC_FLAT;
                end else if (in_rom_area) begin
                    if (rom_hit) dec_src = SRC_MAP;
                end else if (in_ram_area) begin
                    dec_src = SRC_MAP;
                end else if (in_io_page) begin
                    // mirrored input ports and switches across the page
                    unique case (io_off[7:6])
                        IO_PORT0: dec_byte = i_req.port0_levels;
                        IO_PORT1: dec_byte = i_req.port1_levels;
                        IO_DIP:   dec_byte = r_dip;
                        IO_OPEN:  dec_byte = BYTE_FF;
                        default:  dec_byte = BYTE_FF;
                    endcase
                end
            end
            MODE_WRITE: begin
                if (r_flat_mode) begin
                    dec_flat_we = flat_hit;
                end else if (in_ram_area) begin
                    dec_map_we = 1'b1;
                end else if (in_io_page) begin
                    // sound and watchdog writes fall through and are dropped
                    dec_irq_we = (io_off == IRQ_OFFSET);
                    dec_spr_we = (io_off[7:4] == SPRITE_NIB);
                end
            end
            MODE_LOAD: begin
                if (r_flat_mode) begin
                    dec_flat_we = flat_hit;
                end else begin
                    dec_map_we = in_rom_area && rom_hit;
                end
            end
            MODE_PEEK: begin
                if (in_io_page && io_off[7:4] == SPRITE_NIB) begin
                    dec_byte = r_sprite[io_off[3:0]];
                end else if (in_rom_area) begin
                    if (rom_hit) dec_src = SRC_MAP;
                end else if (in_ram_area) begin
                    dec_src = SRC_MAP;
                end
            end
            default: dec_src = SRC_BYTE;
        endcase
    end

    // memory write ports: the sweep owns them while it runs, requests otherwise
    assign clr_map_we  = r_clr_map && ({1'b0, r_clr_cnt} < (CLR_W+1)'(MAP_DEPTH));
    assign clr_flat_we = r_clr_flat && ({1'b0, r_clr_cnt} < (CLR_W+1)'(FLAT_BYTES));

    assign map_we     = clr_map_we || (accept && dec_map_we);
    assign map_waddr  = r_clr_map ? r_clr_cnt[MAP_AW-1:0] : dec_map_addr;
    assign map_wdata  = r_clr_map ? BYTE_ZERO : i_req.write_data;
    assign flat_we    = clr_flat_we || (accept && dec_flat_we);
    assign flat_waddr = r_clr_flat ? r_clr_cnt[FLAT_AW-1:0] : i_req.address[FLAT_AW-1:0];
    assign flat_wdata = r_clr_flat ? BYTE_ZERO : i_req.write_data;

    ammd_ram #(
        .WIDTH (8),
        .DEPTH (MAP_DEPTH)
    ) u_map_ram (
        .i_clk   (i_clk),
        .i_we    (map_we),
        .i_waddr (map_waddr),
        .i_wdata (map_wdata),
        .i_raddr (dec_map_addr),
        .o_rdata (map_rdata)
    );

    ammd_ram #(
        .WIDTH (8),
        .DEPTH (FLAT_BYTES)
    ) u_flat_ram (
        .i_clk   (i_clk),
        .i_we    (flat_we),
        .i_waddr (flat_waddr),
        .i_wdata (flat_wdata),
        .i_raddr (i_req.address[FLAT_AW-1:0]),
        .o_rdata (flat_rdata)
    );

    // configuration, sweep control, interrupt enable and sprite bytes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flat_mode <= 1'b0;
            r_dip       <= DIP_RESET;
            r_irq       <= 1'b0;
            r_clr_map   <= 1'b1;
            r_clr_flat  <= 1'b1;
            r_clr_cnt   <= '0;
            for (int i = 0; i < 16; i++) begin
                r_sprite[i] <= BYTE_ZERO;
            end
        end else begin
            if (clearing) begin
                if (r_clr_cnt == CLR_W'(CLR_DEPTH - 1)) begin
                    r_clr_map  <= 1'b0;
                    r_clr_flat <= 1'b0;
                    r_clr_cnt  <= '0;
                end else begin
                    r_clr_cnt <= r_clr_cnt + CLR_W'(1);
                end
            end
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_FLAT_MODE: begin
                        r_flat_mode <= i_cfg_data[0];
                        // entering flat mode starts from an empty store: restart the sweep
                        if (i_cfg_data[0]) begin
                            r_clr_flat <= 1'b1;
                            r_clr_cnt  <= '0;
                        end
                    end
                    CFG_DIP: r_dip <= i_cfg_data;
                    default: r_dip <= r_dip;
                endcase
            end
            if (accept && dec_irq_we) begin
                r_irq <= i_req.write_data[0];
            end
            if (accept && dec_spr_we) begin
                r_sprite[io_off[3:0]] <= i_req.write_data;
            end
        end
    end

    // read stage: hold the source selection while the memories answer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_src  <= dec_src;
            r_s1_byte <= dec_byte;
        end
    end

    always_comb begin
        case (r_s1_src)
            SRC_MAP:  rsp_s1.read_data = map_rdata;
            SRC_FLAT: rsp_s1.read_data = flat_rdata;
            default:  rsp_s1.read_data = r_s1_byte;
        endcase
        // the request's own irq write has landed by now
        rsp_s1.irq_enable = r_irq;
    end

    // output register plus skid: a finished response waits while the next one is read
    always_comb begin
        n_out_valid  = r_out_valid;
        n_out        = r_out;
        n_skid_valid = r_skid_valid;
        n_skid       = r_skid;
        if (take) begin
            if (r_skid_valid) begin
                n_out        = r_skid;
                n_skid_valid = 1'b0;
            end else begin
                n_out_valid = 1'b0;
            end
        end
        if (r_s1_valid) begin
            if (!r_out_valid || take) begin
                n_out       = rsp_s1;
                n_out_valid = 1'b1;
            end else begin
                n_skid       = rsp_s1;
                n_skid_valid = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_skid <= n_skid;
    end

    assign o_rsp_valid = r_out_valid;
    assign o_rsp       = r_out;

endmodule

### src/ammd_checker.sv
// Port-level checker for the arcade memory map decoder, bound to the top level.
// Depends on ammd_pkg.
module ammd_port_props
    import ammd_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_req_valid,
    input logic                  o_req_ready,
    input logic                  o_rsp_valid,
    input logic                  i_rsp_ready,
    input t_rsp                  o_rsp,
    input logic                  i_cfg_we,
    input logic [CFG_IDX_W-1:0]  i_cfg_index,
    input logic [CFG_DATA_W-1:0] i_cfg_data
);

    // reset starts the clearing sweep, so no request may be taken right after
    a_reset_sweep: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_req_ready)
        else $error("request ready straight after reset");

    // entering flat mode sweeps the flat store before any request
    a_flat_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_we && (i_cfg_index == CFG_FLAT_MODE) && i_cfg_data[0] |=> !o_req_ready)
        else $error("request ready while the flat store is being cleared");

    // one request in the read stage at a time
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req_valid && o_req_ready |=> !o_req_ready)
        else $error("second request taken during a memory read");

    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid && !i_rsp_ready |=> o_rsp_valid && $stable(o_rsp))
        else $error("stalled response dropped or changed");

endmodule

bind arcade_memory_map_decoder ammd_port_props u_ammd_port_props (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_req_valid (i_req_valid),
    .o_req_ready (o_req_ready),
    .o_rsp_valid (o_rsp_valid),
    .i_rsp_ready (i_rsp_ready),
    .o_rsp       (o_rsp),
    .i_cfg_we    (i_cfg_we),
    .i_cfg_index (i_cfg_index),
    .i_cfg_data  (i_cfg_data)
);

### bench/ammd_checker.sv
// Response checker for the arcade memory map decoder: snoops the request, response and
// register ports, predicts every response from its own copy of the map and compares.
// Depends on ammd_pkg.
module ammd_checker
    import ammd_pkg::*;
#(
    parameter int ROM_BYTES  = ROM_BYTES_DEF,
    parameter int FLAT_BYTES = FLAT_BYTES_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_req_valid,
    input  logic                  i_req_ready,
    input  t_req                  i_req,
    input  logic                  i_rsp_valid,
    input  logic                  i_rsp_ready,
    input  t_rsp                  i_rsp,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output int                    o_fail_count,
    output int                    o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [7:0] rom_mem    [ROM_BYTES];
    logic [7:0] video_mem  [1024];
    logic [7:0] colour_mem [1024];
    logic [7:0] work_mem   [2048];
    logic [7:0] flat_mem   [FLAT_BYTES];
    logic [7:0] sprite_mem [16];
    logic       irq_bit;
    logic       flat_on;
    logic [7:0] dip_byte;
    t_rsp       pending_rsp [$];
    int         rsp_seen;

    task automatic clear_flat();
        foreach (flat_mem[i]) flat_mem[i] = BYTE_ZERO;
    endtask

    // Apply one bus access to the map copy and return the response it gives.
    function automatic t_rsp apply_access(t_req r);
        logic [15:0] a;
        logic [7:0]  off;
        logic [7:0]  d;
        logic [7:0]  rd;
        a   = r.address;
        off = a[7:0];
        d   = r.write_data;
        rd  = BYTE_ZERO;
        case (r.mode)
            MODE_READ: begin
                if (flat_on)
                    rd = (int'(a) < FLAT_BYTES) ? flat_mem[a] : BYTE_FF;
                else if (a < 16'h4000)
                    rd = (int'(a) < ROM_BYTES) ? rom_mem[a] : BYTE_FF;
                else if (a < 16'h4400)
                    rd = video_mem[a[9:0]];
                else if (a < 16'h4800)
                    rd = colour_mem[a[9:0]];
                else if (a < 16'h5000)
                    rd = work_mem[a[10:0]];
                else if (a[15:8] == IO_PAGE) begin
                    case (off[7:6])
                        IO_PORT0: rd = r.port0_levels;
                        IO_PORT1: rd = r.port1_levels;
                        IO_DIP:   rd = dip_byte;
                        default:  rd = BYTE_FF;
                    endcase
                end else
                    rd = BYTE_FF;
            end
            MODE_WRITE: begin
                if (flat_on) begin
                    if (int'(a) < FLAT_BYTES) flat_mem[a] = d;
                end else if (a < 16'h4000) begin
                    // drop: ROM is read-only from the bus
                end else if (a < 16'h4400)
                    video_mem[a[9:0]] = d;
                else if (a < 16'h4800)
                    colour_mem[a[9:0]] = d;
                else if (a < 16'h5000)
                    work_mem[a[10:0]] = d;
                else if (a[15:8] == IO_PAGE) begin
                    if (off == IRQ_OFFSET)
                        irq_bit = d[0];
                    else if (off[7:4] == SPRITE_NIB)
                        sprite_mem[off[3:0]] = d;
                end
            end
            MODE_LOAD: begin
                if (flat_on) begin
                    if (int'(a) < FLAT_BYTES) flat_mem[a] = d;
                end else if (int'(a) < ROM_BYTES)
                    rom_mem[a] = d;
            end
            default: begin
                if (a[15:4] == {IO_PAGE, SPRITE_NIB})
                    rd = sprite_mem[a[3:0]];
                else if (a < 16'h4000)
                    rd = (int'(a) < ROM_BYTES) ? rom_mem[a] : BYTE_ZERO;
                else if (a < 16'h4400)
                    rd = video_mem[a[9:0]];
                else if (a < 16'h4800)
                    rd = colour_mem[a[9:0]];
                else if (a < 16'h5000)
                    rd = work_mem[a[10:0]];
            end
        endcase
        return '{read_data: rd, irq_enable: irq_bit};
    endfunction

    always @(posedge i_clk) begin : snoop
        t_rsp want;
        if (!i_rst_n) begin
            foreach (rom_mem[i]) rom_mem[i] = BYTE_ZERO;
            foreach (video_mem[i]) video_mem[i] = BYTE_ZERO;
            foreach (colour_mem[i]) colour_mem[i] = BYTE_ZERO;
            foreach (work_mem[i]) work_mem[i] = BYTE_ZERO;
            foreach (sprite_mem[i]) sprite_mem[i] = BYTE_ZERO;
            clear_flat();
            irq_bit  = 1'b0;
            flat_on  = 1'b0;
            dip_byte = DIP_RESET;
            pending_rsp.delete();
        end else begin
            // Responses first: one accepted on this edge belongs to an older request.
            if (i_rsp_valid && i_rsp_ready) begin
                if (pending_rsp.size() == 0) begin
                    if (o_fail_count < 10)
                        $display("%0t: response %0d arrived with no request outstanding",
                                 $realtime, rsp_seen);
                    o_fail_count++;
                end else begin
                    want = pending_rsp.pop_front();
                    if (i_rsp.read_data !== want.read_data ||
                        i_rsp.irq_enable !== want.irq_enable) begin
                        if (o_fail_count < 10)
                            $display({"%0t: response %0d: read_data exp %02h got %02h, ",
                                      "irq_enable exp %0b got %0b"}, $realtime, rsp_seen,
                                     want.read_data, i_rsp.read_data,
                                     want.irq_enable, i_rsp.irq_enable);
                        o_fail_count++;
                    end
                end
                rsp_seen++;
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_FLAT_MODE: begin
                        flat_on = i_cfg_data[0];
                        if (flat_on) clear_flat();
                    end
                    CFG_DIP: dip_byte = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_req_valid && i_req_ready)
                pending_rsp.push_back(apply_access(i_req));
        end
        o_pending = pending_rsp.size();
    end

endmodule

### bench/tb.sv
// Top of the arcade memory map decoder testbench: clock, reset, request and register
// stimulus, response back-pressure, watchdog and verdict.
// Depends on ammd_pkg, ammd_checker and the arcade_memory_map_decoder RTL.
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import ammd_pkg::*;

    // A memory sweep after reset or a flat mode switch holds off requests; the limit
    // allows for that several times over before calling a hang.
    localparam int WATCHDOG_LIMIT = 4 * FLAT_BYTES_DEF;
    localparam int RANDOM_ITEMS   = 1750;
    localparam int PHASES         = 6;

    logic                  clk;
    logic                  rst_n;
    logic                  req_valid;
    logic                  req_ready;
    t_req                  req;
    logic                  rsp_valid;
    logic                  rsp_ready;
    t_rsp                  rsp;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    int                    fail_count;
    int                    pending;
    int                    idle_cycles;
    int                    mode_count [4];
    int                    cfg_writes;
    bit                    burst;

    arcade_memory_map_decoder i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_req_valid (req_valid),
        .o_req_ready (req_ready),
        .i_req       (req),
        .o_rsp_valid (rsp_valid),
        .i_rsp_ready (rsp_ready),
        .o_rsp       (rsp),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    ammd_checker i_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_req_valid  (req_valid),
        .i_req_ready  (req_ready),
        .i_req        (req),
        .i_rsp_valid  (rsp_valid),
        .i_rsp_ready  (rsp_ready),
        .i_rsp        (rsp),
        .i_cfg_we     (cfg_we),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Gap after a request: mostly none, some short, a few long; none at all in a burst.
    function automatic int gap_len();
        int pick;
        pick = $urandom_range(0, 99);
        if (burst || pick < 65) return 0;
        if (pick < 95) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Aim most addresses at small windows so that reads find earlier writes, the rest
    // anywhere so that every address bit moves.
    function automatic logic [15:0] pick_address();
        logic [15:0] off;
        off = $urandom_range(0, 1) ? 16'($urandom_range(0, 15)) : 16'($urandom);
        case ($urandom_range(0, 9))
            0, 1:    return off & 16'h3FFF;
            2:       return 16'h4000 | (off & 16'h03FF);
            3:       return 16'h4400 | (off & 16'h03FF);
            4:       return 16'h4800 | (off & 16'h07FF);
            5:       return {IO_PAGE, ($urandom_range(0, 1) ? IRQ_OFFSET : 8'($urandom))};
            6:       return {IO_PAGE, SPRITE_NIB, off[3:0]};
            7:       return 16'($urandom_range(16'h5100, 16'hFFFF));
            8:       return {12'hFFF, off[3:0]};
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic t_req random_request();
        t_req r;
        r.mode         = t_mode'($urandom_range(0, 3));
        r.address      = pick_address();
        r.write_data   = 8'($urandom);
        r.port0_levels = 8'($urandom);
        r.port1_levels = 8'($urandom);
        return r;
    endfunction

    // Present a request at the falling edge and hold it until the block takes it, then
    // either keep valid high for the next one or drop it for a gap.
    task automatic issue(input t_req r);
        int gap;
        @(negedge clk);
        req_valid = 1'b1;
        req       = r;
        mode_count[r.mode]++;
        do @(posedge clk); while (!req_ready);
        gap = gap_len();
        if (gap != 0) begin
            @(negedge clk);
            req_valid = 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
    endtask

    task automatic access(input t_mode m, input logic [15:0] a, input logic [7:0] d);
        t_req r;
        r            = random_request();
        r.mode       = m;
        r.address    = a;
        r.write_data = d;
        issue(r);
    endtask

    // Stop sending and hold off until every outstanding response has been returned.
    task automatic drain();
        @(negedge clk);
        req_valid = 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] d);
        @(negedge clk);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = d;
        @(negedge clk);
        cfg_we    = 1'b0;
        cfg_writes++;
    endtask

    // Response back-pressure: mostly ready, short random stalls, the odd long stall and
    // stretches with no stall at all.
    initial begin : rsp_pacing
        int pick;
        rsp_ready = 1'b0;
        forever begin
            @(negedge clk);
            pick = $urandom_range(0, 99);
            if (pick < 5) begin
                rsp_ready = 1'b1;
                repeat ($urandom_range(50, 200)) @(negedge clk);
            end else if (pick < 8) begin
                rsp_ready = 1'b0;
                repeat ($urandom_range(8, 40)) @(negedge clk);
            end else
                rsp_ready = (pick >= 30);
        end
    end

    always @(posedge clk) begin
        if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial begin : watchdog
        wait (idle_cycles >= WATCHDOG_LIMIT);
        $display("Watchdog: nothing moved on either port for %0d cycles", WATCHDOG_LIMIT);
        $display("== FAIL ==");
        $finish;
    end

    initial begin : stimulus
        logic [7:0] dip;
        req_valid = 1'b0;
        req       = '0;
        cfg_we    = 1'b0;
        cfg_index = CFG_FLAT_MODE;
        cfg_data  = '0;
        burst     = 1'b0;
        rst_n     = 1'b0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed part, registers at their reset values.
        // ROM: load both ends, read back, try to overwrite from the bus, peek.
        access(MODE_LOAD,  16'h0000, 8'hA5);
        access(MODE_LOAD,  16'h3FFF, 8'h5A);
        access(MODE_READ,  16'h0000, 8'h00);
        access(MODE_WRITE, 16'h3FFF, 8'hFF);
        access(MODE_PEEK,  16'h3FFF, 8'h00);
        // Video, colour and work RAM at their edges.
        access(MODE_WRITE, 16'h4000, 8'hFF);
        access(MODE_WRITE, 16'h47FF, 8'h80);
        access(MODE_WRITE, 16'h4FFF, 8'h01);
        access(MODE_READ,  16'h4000, 8'h00);
        access(MODE_READ,  16'h47FF, 8'h00);
        access(MODE_PEEK,  16'h4FFF, 8'h00);
        // I/O page: interrupt enable on, a sprite byte that reads back as port 1 but
        // peeks as itself, each read window, interrupt enable off again.
        access(MODE_WRITE, 16'h5000, 8'hFF);
        access(MODE_WRITE, 16'h506F, 8'h3C);
        access(MODE_PEEK,  16'h506F, 8'h00);
        access(MODE_READ,  16'h506F, 8'h00);
        access(MODE_READ,  16'h503F, 8'h00);
        access(MODE_READ,  16'h5080, 8'h00);
        access(MODE_READ,  16'h50FF, 8'h00);
        access(MODE_WRITE, 16'h5000, 8'hFE);
        // Unmapped space reads as FF, drops writes and peeks as zero.
        access(MODE_READ,  16'h5100, 8'h00);
        access(MODE_WRITE, 16'hFFFF, 8'h12);
        access(MODE_PEEK,  16'hFFFF, 8'h00);

        // Flat mode: top of memory, a load that lands in the flat store, a peek that
        // still sees the ROM, and an I/O address that is now plain RAM.
        drain();
        cfg_write(CFG_FLAT_MODE, 8'h01);
        cfg_write(CFG_DIP, 8'h00);
        access(MODE_WRITE, 16'hFFFF, 8'hAB);
        access(MODE_READ,  16'hFFFF, 8'h00);
        access(MODE_LOAD,  16'h0000, 8'h77);
        access(MODE_PEEK,  16'h0000, 8'h00);
        access(MODE_READ,  16'h5080, 8'h00);

        // Random part, one register setting per phase; flat mode twice more.
        for (int phase = 0; phase < PHASES; phase++) begin
            drain();
            cfg_write(CFG_FLAT_MODE, (phase == 1 || phase == 4) ? 8'h01 : 8'h00);
            dip = (phase == 0) ? 8'hFF : (phase == 2) ? DIP_RESET :
                  (phase == 3) ? 8'h00 : 8'($urandom);
            cfg_write(CFG_DIP, dip);
            for (int n = 0; n < RANDOM_ITEMS / PHASES; n++) begin
                if (n % 50 == 0) burst = ($urandom_range(0, 3) == 0);
                // hold off mid-phase until every response is home
                if (n == 150 && phase % 2 == 0) drain();
                issue(random_request());
            end
        end

        drain();
        repeat (8) @(posedge clk);
        $display("Sent %0d reads, %0d writes, %0d ROM loads and %0d peeks",
                 mode_count[MODE_READ], mode_count[MODE_WRITE],
                 mode_count[MODE_LOAD], mode_count[MODE_PEEK]);
        $display("over %0d register writes in mapped and flat modes, stalls on both sides",
                 cfg_writes);
        if (fail_count == 0 && pending == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
